// ===== sv/dda_pkg.sv =====
// Package for the DDA line rasterizer: coordinate width, command codes,
// request and pixel payload structs, controller state and control structs.
// No dependencies.
package dda_pkg;

  // Coordinate width is fixed by the payload fields
  localparam int COORD_BITS = 12;
  // Default fraction width of the position arithmetic
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } dda_cmd_t;

  typedef struct packed {
    dda_cmd_t                      command;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [31:0]            pen_color;
  } dda_in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [31:0]            pixel_color;
    logic                          last_pixel;
  } dda_out_req_t;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } dda_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;    // start request accepted
    logic advance;  // step request accepted while a line runs
    logic div_run;  // divider iterates this cycle
  } dda_cmd_bus_t;

  // Datapath to controller
  typedef struct packed {
    logic single_pixel;  // incoming line has at most one pixel
    logic div_done;      // divider in its final iteration
    logic last_step;     // next step emits the final pixel
    logic out_busy;      // output register holds a pixel
  } dda_sts_bus_t;

endpackage

// ===== sv/dda_ctrl.sv =====
// Controller of the DDA line rasterizer: input handshake and the
// idle / divide / run state machine. Depends on dda_pkg.
module dda_ctrl
  import dda_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  dda_cmd_t      in_command,
  output logic          in_stall,
  input  logic          out_stall,
  input  dda_sts_bus_t  sts,
  output dda_cmd_bus_t  cmd
);

  dda_state_t state_r, state_nxt;
  logic       accept;

  // Stall while dividing or while the output register cannot drain
  assign in_stall = (state_r == ST_DIV) | (sts.out_busy & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cmd.start   = accept & (in_command == CMD_START);
    cmd.advance = accept & (in_command == CMD_STEP) & (state_r == ST_RUN);
    cmd.div_run = (state_r == ST_DIV);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_RUN: begin
        if (cmd.start) begin
          state_nxt = sts.single_pixel ? ST_IDLE : ST_DIV;
        end else if (cmd.advance && sts.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> in_stall)
    else $error("input not stalled during division");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !sts.single_pixel) |=> (state_r == ST_DIV))
    else $error("multi-pixel start did not enter division");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> (state_r == ST_RUN))
    else $error("division end did not start the run");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && sts.last_step && !cmd.start) |=> (state_r == ST_IDLE))
    else $error("final pixel did not return to idle");

endmodule

// ===== sv/dda_datapath.sv =====
// Datapath of the DDA line rasterizer: delta and major-axis magnitude,
// restoring divider for the increments, position stepping, rounding and
// the output register. Depends on dda_pkg.
module dda_datapath
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dda_in_req_t   in_data,
  input  dda_cmd_bus_t  cmd,
  input  logic          out_stall,
  output dda_sts_bus_t  sts,
  output logic          out_valid,
  output dda_out_req_t  out_data
);

  localparam int C  = COORD_BITS;
  localparam int PW = COORD_BITS + FRAC_BITS;   // position width
  localparam int IW = FRAC_BITS + 2;            // increment width
  localparam int DW = COORD_BITS + 1;           // delta width
  localparam int CW = $clog2(FRAC_BITS + 1);    // divider count width
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [IW-1:0]  inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic [C-1:0]          steps_r, steps_nxt;
  logic [C-1:0]          mx_r, mx_nxt;
  logic [31:0]           color_r, color_nxt;
  logic [C:0]            rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [FRAC_BITS-1:0]  q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic                  neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dda_out_req_t          out_data_r, out_data_nxt;

  logic signed [DW-1:0]  dx, dy, neg_dx, neg_dy;
  logic [C-1:0]          ax, ay, mx;
  logic                  ge_x, ge_y;
  logic [C:0]            diff_x, diff_y, r1_x, r1_y;
  logic [FRAC_BITS:0]    qf_x, qf_y;
  logic signed [PW-1:0]  sum_x, sum_y;

  // Half away from zero: add half, or half minus one when negative, then floor
  function automatic logic [C-1:0] round_pos(input logic [PW-1:0] p);
    logic [PW-1:0] bias;
    logic [PW-1:0] s;
    bias = p[PW-1] ? HALF - PW'(1) : HALF;
    s    = p + bias;
    return s[PW-1:FRAC_BITS];
  endfunction

  // Deltas and major-axis magnitude of the incoming line
  always_comb begin
    dx     = {in_data.end_x[C-1], in_data.end_x} - {in_data.start_x[C-1], in_data.start_x};
    dy     = {in_data.end_y[C-1], in_data.end_y} - {in_data.start_y[C-1], in_data.start_y};
    neg_dx = -dx;
    neg_dy = -dy;
    ax     = dx[DW-1] ? neg_dx[C-1:0] : dx[C-1:0];
    ay     = dy[DW-1] ? neg_dy[C-1:0] : dy[C-1:0];
    mx     = (ax > ay) ? ax : ay;
  end

  // One restoring division step per axis
  always_comb begin
    diff_x = rem_x_r - {1'b0, mx_r};
    diff_y = rem_y_r - {1'b0, mx_r};
    ge_x   = (rem_x_r >= {1'b0, mx_r});
    ge_y   = (rem_y_r >= {1'b0, mx_r});
    r1_x   = ge_x ? diff_x : rem_x_r;
    r1_y   = ge_y ? diff_y : rem_y_r;
    qf_x   = {q_x_r, ge_x};
    qf_y   = {q_y_r, ge_y};
  end

  // Next position
  always_comb begin
    sum_x = pos_x_r + {{(PW-IW){inc_x_r[IW-1]}}, inc_x_r};
    sum_y = pos_y_r + {{(PW-IW){inc_y_r[IW-1]}}, inc_y_r};
  end

  assign sts.single_pixel = (mx[C-1:1] == '0);
  assign sts.div_done     = (cnt_r == CW'(FRAC_BITS));
  assign sts.last_step    = (steps_r == C'(1));
  assign sts.out_busy     = out_valid_r;

  // Register updates
  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    inc_x_nxt     = inc_x_r;
    inc_y_nxt     = inc_y_r;
    steps_nxt     = steps_r;
    mx_nxt        = mx_r;
    color_nxt     = color_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    q_x_nxt       = q_x_r;
    q_y_nxt       = q_y_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (cmd.start) begin
      pos_x_nxt     = {in_data.start_x, {FRAC_BITS{1'b0}}};
      pos_y_nxt     = {in_data.start_y, {FRAC_BITS{1'b0}}};
      steps_nxt     = mx - C'(1);
      mx_nxt        = mx;
      color_nxt     = in_data.pen_color;
      rem_x_nxt     = {1'b0, ax};
      rem_y_nxt     = {1'b0, ay};
      q_x_nxt       = '0;
      q_y_nxt       = '0;
      neg_x_nxt     = dx[DW-1];
      neg_y_nxt     = dy[DW-1];
      cnt_nxt       = '0;
      out_valid_nxt = 1'b1;
      out_data_nxt.pixel_x     = in_data.start_x;
      out_data_nxt.pixel_y     = in_data.start_y;
      out_data_nxt.pixel_color = in_data.pen_color;
      out_data_nxt.last_pixel  = sts.single_pixel;
    end else if (cmd.div_run) begin
      rem_x_nxt = {r1_x[C-1:0], 1'b0};
      rem_y_nxt = {r1_y[C-1:0], 1'b0};
      q_x_nxt   = qf_x[FRAC_BITS-1:0];
      q_y_nxt   = qf_y[FRAC_BITS-1:0];
      cnt_nxt   = cnt_r + CW'(1);
      if (sts.div_done) begin
        inc_x_nxt = neg_x_r ? -$signed({1'b0, qf_x}) : $signed({1'b0, qf_x});
        inc_y_nxt = neg_y_r ? -$signed({1'b0, qf_y}) : $signed({1'b0, qf_y});
      end
    end else if (cmd.advance) begin
      pos_x_nxt     = sum_x;
      pos_y_nxt     = sum_y;
      steps_nxt     = steps_r - C'(1);
      out_valid_nxt = 1'b1;
      out_data_nxt.pixel_x     = round_pos(sum_x);
      out_data_nxt.pixel_y     = round_pos(sum_y);
      out_data_nxt.pixel_color = color_r;
      out_data_nxt.last_pixel  = sts.last_step;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    inc_x_r    <= inc_x_nxt;
    inc_y_r    <= inc_y_nxt;
    steps_r    <= steps_nxt;
    mx_r       <= mx_nxt;
    color_r    <= color_nxt;
    rem_x_r    <= rem_x_nxt;
    rem_y_r    <= rem_y_nxt;
    q_x_r      <= q_x_nxt;
    q_y_r      <= q_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// DDA line rasterizer. A start request loads both endpoints and a color and
// emits the first pixel at once; each step request emits the next pixel of
// the half-open line, position kept in signed fixed point with FRAC_BITS
// fraction bits and rounded half away from zero. A step is taken every cycle
// while the output register drains, so a running line yields one pixel per
// cycle. A start of a line longer than one pixel is accepted, then the
// restoring divider forms both increments while in_stall is high. A step
// request while no line runs is accepted and produces no pixel.
// Top level; depends on dda_pkg, dda_ctrl and dda_datapath.
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dda_in_req_t   in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dda_out_req_t  out_data
);

  dda_cmd_bus_t cmd;
  dda_sts_bus_t sts;

  // Sequencing and handshake
  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic and output register
  dda_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sim/testbench.sv =====
// Testbench for dda_line_rasterizer: directed lines, a back-pressure run, then
// random lines, each pixel checked against a behavioral rasterizer model kept
// in this file or a typed pixel. Depends on dda_pkg and dda_line_rasterizer.
`timescale 1ns / 100ps

module testbench
  import dda_pkg::*;
();

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT   = 3000;   // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 60;     // covers the start divider and output register
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int ITEM_GOAL    = 900;

  typedef enum logic [1:0] {
    ROW_PRED,  // expectation from the line model
    ROW_NONE,  // no pixel expected
    ROW_PIX    // pixel typed into the table
  } row_kind_t;

  typedef struct {
    dda_in_req_t  req;
    row_kind_t    kind;
    dda_out_req_t pix;
  } stim_row_t;

  logic         clk;
  logic         rst_n     = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_stall;
  dda_in_req_t  in_data   = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  dda_out_req_t out_data;

  // Row info travels with the request so the monitor can see it
  row_kind_t    cur_kind = ROW_PRED;
  dda_out_req_t cur_pix  = '0;

  dda_out_req_t pixel_q[$];
  stim_row_t    dir_rows[$];
  int unsigned  req_cnt      = 0;
  int unsigned  pix_cnt      = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  tx_max       = 18;
  int unsigned  rx_max       = 18;
  int unsigned  rx_hold      = 0;

  // Line model state
  longint      pos_x, pos_y, inc_x, inc_y;
  longint      steps_left;
  bit          line_active;
  logic [31:0] line_color;

  dda_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Round half away from zero, wrapped to the coordinate width
  function automatic logic [COORD_BITS-1:0] round_pos(input longint p);
    longint half;
    longint r;
    half = longint'(1) << (FRAC - 1);
    if (p >= 0) r = (p + half) >>> FRAC;
    else r = -((-p + half) >>> FRAC);
    return r[COORD_BITS-1:0];
  endfunction

  // Advance the line model by one request; returns 1 when a pixel comes out
  function automatic bit next_pixel(input dda_in_req_t req, output dda_out_req_t pix);
    longint sx, sy, dx, dy, ax, ay, span, one;
    pix = '0;
    one = longint'(1) << FRAC;
    if (req.command == CMD_START) begin
      sx = longint'($signed(req.start_x));
      sy = longint'($signed(req.start_y));
      dx = longint'($signed(req.end_x)) - sx;
      dy = longint'($signed(req.end_y)) - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax > ay) ? ax : ay;
      line_color = req.pen_color;
      pos_x = sx * one;
      pos_y = sy * one;
      if (span == 0) begin
        inc_x = 0;
        inc_y = 0;
        steps_left = 0;
        line_active = 1'b0;
      end else begin
        // Quotient truncates toward zero, major axis gets exactly +-1.0
        inc_x = (dx * one) / span;
        inc_y = (dy * one) / span;
        steps_left = span - 1;
        line_active = (steps_left != 0);
      end
      pix.pixel_x = req.start_x;
      pix.pixel_y = req.start_y;
      pix.pixel_color = req.pen_color;
      pix.last_pixel = !line_active;
      return 1'b1;
    end
    // Step while idle is swallowed
    if (!line_active) return 1'b0;
    pos_x += inc_x;
    pos_y += inc_y;
    steps_left--;
    line_active = (steps_left != 0);
    pix.pixel_x = round_pos(pos_x);
    pix.pixel_y = round_pos(pos_y);
    pix.pixel_color = line_color;
    pix.last_pixel = !line_active;
    return 1'b1;
  endfunction

  function automatic dda_in_req_t line_req(input int sx, input int sy, input int ex,
                                           input int ey, input logic [31:0] color);
    dda_in_req_t req;
    req.command   = CMD_START;
    req.start_x   = COORD_BITS'(sx);
    req.start_y   = COORD_BITS'(sy);
    req.end_x     = COORD_BITS'(ex);
    req.end_y     = COORD_BITS'(ey);
    req.pen_color = color;
    return req;
  endfunction

  // Step request with junk in the ignored fields
  function automatic dda_in_req_t step_req();
    dda_in_req_t req;
    req.command   = CMD_STEP;
    req.start_x   = COORD_BITS'($urandom);
    req.start_y   = COORD_BITS'($urandom);
    req.end_x     = COORD_BITS'($urandom);
    req.end_y     = COORD_BITS'($urandom);
    req.pen_color = $urandom;
    return req;
  endfunction

  function automatic dda_out_req_t pixel_at(input int x, input int y,
                                            input logic [31:0] color, input bit last);
    dda_out_req_t pix;
    pix.pixel_x     = COORD_BITS'(x);
    pix.pixel_y     = COORD_BITS'(y);
    pix.pixel_color = color;
    pix.last_pixel  = last;
    return pix;
  endfunction

  // Called right after a falling edge; returns right after the falling edge
  // that follows acceptance
  task automatic send_req(input dda_in_req_t req, input row_kind_t kind,
                          input dda_out_req_t pix);
    int unsigned gap;
    int unsigned target;
    gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    cur_kind <= kind;
    cur_pix  <= pix;
    target = req_cnt + 1;
    do @(negedge clk); while (req_cnt != target);
  endtask

  // Sender pause until every expected pixel is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // One line: start plus its steps, sometimes cut short or followed by idle steps
  task automatic send_line(input int reach, input bit wide);
    int sx, sy, ex, ey, dx, dy, span, n;
    sx = $urandom_range(0, 4095) - 2048;
    sy = $urandom_range(0, 4095) - 2048;
    if (wide) begin
      ex = $urandom_range(0, 4095) - 2048;
      ey = $urandom_range(0, 4095) - 2048;
    end else begin
      dx = int'($urandom_range(0, 2 * reach)) - reach;
      dy = int'($urandom_range(0, 2 * reach)) - reach;
      ex = (sx + dx > 2047 || sx + dx < -2048) ? sx - dx : sx + dx;
      ey = (sy + dy > 2047 || sy + dy < -2048) ? sy - dy : sy + dy;
    end
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    span = (dx > dy) ? dx : dy;
    send_req(line_req(sx, sy, ex, ey, $urandom), ROW_PRED, '0);
    n = (span > 0) ? span - 1 : 0;
    // Long lines are abandoned early by the next start
    if (wide) n = $urandom_range(0, (n < 30) ? n : 30);
    else if ($urandom_range(0, 6) == 0) n = $urandom_range(0, n);
    else if ($urandom_range(0, 6) == 0) n += $urandom_range(1, 3);
    repeat (n) send_req(step_req(), ROW_PRED, '0);
  endtask

  // Request side: record acceptance and queue the expected pixel
  always @(posedge clk) begin
    dda_out_req_t pix;
    bit           has_pix;
    if (rst_n && in_valid && !in_stall) begin
      has_pix = next_pixel(in_data, pix);
      case (cur_kind)
        ROW_PRED: if (has_pix) pixel_q.push_back(pix);
        ROW_PIX:  pixel_q.push_back(cur_pix);
        default:  ;
      endcase
      req_cnt++;
    end
  end

  // Pixel side: compare against the oldest expectation
  always @(posedge clk) begin
    dda_out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%h last=%b",
                 $time, out_data.pixel_x, out_data.pixel_y, out_data.pixel_color,
                 out_data.last_pixel);
        mismatch_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data.pixel_x != want.pixel_x || out_data.pixel_y != want.pixel_y ||
            out_data.pixel_color != want.pixel_color ||
            out_data.last_pixel != want.last_pixel) begin
          $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h last=%b",
                   $time, want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel);
          $display("%0t:                 actual   x=%0d y=%0d color=%h last=%b",
                   $time, out_data.pixel_x, out_data.pixel_y, out_data.pixel_color,
                   out_data.last_pixel);
          mismatch_cnt++;
        end
      end
      pix_cnt++;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall before each pixel, or one long hold-off on request
  initial begin
    int unsigned wait_cycles;
    int unsigned target;
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        wait_cycles = rx_hold;
        rx_hold = 0;
      end else begin
        wait_cycles = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      target = pix_cnt + 1;
      do @(negedge clk); while (pix_cnt != target);
    end
  end

  // Sender and run control
  initial begin
    int unsigned sel;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, single-pixel lines, idle steps, restarts, rounding ties
    dir_rows = '{
      '{step_req(), ROW_NONE, '0},
      '{line_req(5, -7, 5, -7, 32'hFFFF_FFFF), ROW_PIX,
        pixel_at(5, -7, 32'hFFFF_FFFF, 1'b1)},
      '{step_req(), ROW_NONE, '0},
      '{line_req(-2048, -2048, -2048, -2048, 32'h0), ROW_PIX,
        pixel_at(-2048, -2048, 32'h0, 1'b1)},
      '{line_req(2047, 2047, 2046, 2047, 32'hA5A5_A5A5), ROW_PIX,
        pixel_at(2047, 2047, 32'hA5A5_A5A5, 1'b1)},
      '{line_req(0, 0, -1, 1, 32'h5A5A_5A5A), ROW_PIX,
        pixel_at(0, 0, 32'h5A5A_5A5A, 1'b1)},
      '{step_req(), ROW_NONE, '0},
      '{line_req(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF), ROW_PIX,
        pixel_at(-2048, -2048, 32'hFFFF_FFFF, 1'b0)},
      '{step_req(), ROW_PRED, '0},
      '{step_req(), ROW_PRED, '0},
      '{step_req(), ROW_PRED, '0},
      '{line_req(2047, 2047, -2048, -2048, 32'h0), ROW_PIX,
        pixel_at(2047, 2047, 32'h0, 1'b0)},
      '{step_req(), ROW_PRED, '0},
      '{step_req(), ROW_PRED, '0},
      '{line_req(2047, -2048, -2048, 2047, 32'h1234_5678), ROW_PIX,
        pixel_at(2047, -2048, 32'h1234_5678, 1'b0)},
      '{step_req(), ROW_PRED, '0},
      '{line_req(0, 0, 4, 2, 32'h0F0F_0F0F), ROW_PIX,
        pixel_at(0, 0, 32'h0F0F_0F0F, 1'b0)},
      '{step_req(), ROW_PIX, pixel_at(1, 1, 32'h0F0F_0F0F, 1'b0)},
      '{step_req(), ROW_PIX, pixel_at(2, 1, 32'h0F0F_0F0F, 1'b0)},
      '{step_req(), ROW_PIX, pixel_at(3, 2, 32'h0F0F_0F0F, 1'b1)},
      '{step_req(), ROW_NONE, '0},
      '{line_req(0, 0, -4, -2, 32'hF0F0_F0F0), ROW_PIX,
        pixel_at(0, 0, 32'hF0F0_F0F0, 1'b0)},
      '{step_req(), ROW_PIX, pixel_at(-1, -1, 32'hF0F0_F0F0, 1'b0)},
      '{step_req(), ROW_PRED, '0},
      '{step_req(), ROW_PRED, '0}
    };
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].kind, dir_rows[i].pix);
    wait_drained();

    // Back-pressure: receiver holds off while steps keep coming
    rx_hold = HOLD_CYCLES;
    tx_max = 0;
    send_req(line_req(-1000, 3, -700, -150, $urandom), ROW_PRED, '0);
    repeat (299) send_req(step_req(), ROW_PRED, '0);
    wait_drained();
    tx_max = 18;

    // Random lines with changing idle profiles
    while (req_cnt < ITEM_GOAL) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_max = 0;
          1:       tx_max = 4;
          default: tx_max = 18;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_max = 0;
          1:       rx_max = 4;
          default: rx_max = 18;
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < 6) send_req(step_req(), ROW_PRED, '0);
      else if (sel < 10) send_line(0, 1'b1);
      else if (sel < 15) send_line(200, 1'b0);
      else send_line(24, 1'b0);
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    // Drain and report
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    mismatch_cnt += pixel_q.size();
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dda_pkg.sv
sv/dda_ctrl.sv
sv/dda_datapath.sv
sv/dda_line_rasterizer.sv
sim/testbench.sv
